>>> src/recycling_index_allocator_core_assert.svh
// Assertion macros for the index allocator checker.
`ifndef RECYCLING_INDEX_ALLOCATOR_CORE_ASSERT_SVH
`define RECYCLING_INDEX_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ria_pkg.sv
`timescale 1ns / 1ps

package ria_pkg;

  localparam int HEAP_SIZE_DEF = 16;
  localparam int GRANT_W       = 4;
  localparam int SLOT_W        = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // queue control broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

endpackage

>>> src/ria_cell.sv
`timescale 1ns / 1ps

module ria_cell #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  ria_pkg::queue_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]             count,
  input  logic [ria_pkg::GRANT_W-1:0]  wr_data,
  input  logic [ria_pkg::GRANT_W-1:0]  right_data,
  output logic [ria_pkg::GRANT_W-1:0]  data
);
  import ria_pkg::*;

  logic is_tail;

  // the first free cell sits at the current fill level
  assign is_tail = (count == CNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      data <= right_data;
    end else if (ctrl.push && is_tail) begin
      data <= wr_data;
    end
  end

endmodule

>>> src/ria_chain.sv
`timescale 1ns / 1ps

module ria_chain #(
  parameter int HEAP_SIZE = ria_pkg::HEAP_SIZE_DEF
) (
  input  logic                                 clk,
  input  ria_pkg::queue_ctrl_t                 ctrl,
  input  logic [$clog2(HEAP_SIZE + 1)-1:0]     count,
  input  logic [ria_pkg::GRANT_W-1:0]          wr_data,
  output logic [ria_pkg::GRANT_W-1:0]          head_data
);
  import ria_pkg::*;

  localparam int CNT_W = $clog2(HEAP_SIZE + 1);

  // cell_data[i] is held by cell i; the extra tap feeds the last cell on a pop
  logic [GRANT_W-1:0] cell_data [HEAP_SIZE+1];

  assign cell_data[HEAP_SIZE] = '0;
  assign head_data            = cell_data[0];

  for (genvar gi = 0; gi < HEAP_SIZE; gi++) begin : g_cell
    ria_cell #(
      .CNT_W (CNT_W),
      .INDEX (gi)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .wr_data    (wr_data),
      .right_data (cell_data[gi+1]),
      .data       (cell_data[gi])
    );
  end

endmodule

>>> src/recycling_index_allocator_core.sv
`timescale 1ns / 1ps

// Index allocator: one request per transaction on s_*, one answer per request on m_*.
// A request is taken every cycle while the answer register is empty or being drained,
// and its answer is registered for the next cycle. Freed indices wait in a chain of
// HEAP_SIZE cells that shift one place towards the head on every allocate served from
// that queue; when the queue is empty a bump counter hands out never-used indices.
// Queue storage needs no clearing pass after reset: the fill count alone says which
// cells hold data. Only the low four bits of an index are returned in granted_index.

module recycling_index_allocator_core #(
  parameter int HEAP_SIZE = ria_pkg::HEAP_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] slot_index
  input  logic       s_tuser,   // [0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] granted_index, [4] can_allocate, [7:5] zero
  output logic [1:0] m_tuser    // [1:0] status
);
  import ria_pkg::*;

  localparam int CNT_W = $clog2(HEAP_SIZE + 1);

  logic [CNT_W-1:0]   queue_count, queue_count_next;
  logic [CNT_W-1:0]   next_fresh, next_fresh_next;
  logic [GRANT_W-1:0] head_data;
  logic [8:0]         fresh_ext;
  queue_ctrl_t        ctrl;

  logic               accept;
  logic               is_free;
  logic               queue_empty, queue_full, fresh_left, in_range;
  logic [GRANT_W-1:0] grant_next;
  status_t            status_next;
  logic               can_next;

  logic [GRANT_W-1:0] granted_index;
  status_t            status;
  logic               can_allocate;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_free  = (s_tuser == CMD_FREE);

  assign queue_empty = (queue_count == '0);
  assign queue_full  = (queue_count == CNT_W'(HEAP_SIZE));
  assign fresh_left  = (next_fresh != CNT_W'(HEAP_SIZE));
  assign in_range    = (9'(s_tdata) < 9'(HEAP_SIZE));
  assign fresh_ext   = 9'(next_fresh);

  always_comb begin
    ctrl             = '0;
    grant_next       = '0;
    status_next      = ST_OK;
    queue_count_next = queue_count;
    next_fresh_next  = next_fresh;
    if (!is_free) begin
      if (!queue_empty) begin
        ctrl.pop         = accept;
        grant_next       = head_data;
        queue_count_next = queue_count - 1'b1;
      end else if (fresh_left) begin
        grant_next      = fresh_ext[GRANT_W-1:0];
        next_fresh_next = next_fresh + 1'b1;
      end else begin
        status_next = ST_EXHAUSTED;
      end
    end else begin
      if (!in_range) begin
        status_next = ST_RANGE;
      end else if (queue_full) begin
        status_next = ST_FULL;
      end else begin
        ctrl.push        = accept;
        queue_count_next = queue_count + 1'b1;
      end
    end
    can_next = (next_fresh_next != CNT_W'(HEAP_SIZE)) || (queue_count_next != '0);
  end

  ria_chain #(
    .HEAP_SIZE (HEAP_SIZE)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .count     (queue_count),
    .wr_data   (s_tdata[GRANT_W-1:0]),
    .head_data (head_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= '0;
      next_fresh  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        queue_count <= queue_count_next;
        next_fresh  <= next_fresh_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      granted_index <= grant_next;
      status        <= status_next;
      can_allocate  <= can_next;
    end
  end

  assign m_tdata = {3'b000, can_allocate, granted_index};
  assign m_tuser = status;

endmodule

>>> src/ria_checker.sv
`timescale 1ns / 1ps

`include "recycling_index_allocator_core_assert.svh"

module ria_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);
  import ria_pkg::*;

  // a stalled answer stays put
  `RIA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "answer changed while stalled")

  // an empty answer register never blocks requests
  `RIA_ASSERT_NOW(a_ready, !m_tvalid, s_tready, "input stalled with empty output")

  // every accepted request is answered on the next cycle
  `RIA_ASSERT_NEXT(a_answer, s_tvalid && s_tready, m_tvalid, "no answer after request")

  // failed transactions grant nothing
  `RIA_ASSERT_NOW(a_zero_grant, m_tvalid && (m_tuser != ST_OK),
    m_tdata[3:0] == 4'd0, "non-zero grant on error")

  // exhaustion leaves nothing to allocate
  `RIA_ASSERT_NOW(a_exhausted, m_tvalid && (m_tuser == ST_EXHAUSTED),
    !m_tdata[4], "can_allocate set when exhausted")

endmodule

bind recycling_index_allocator_core ria_checker u_ria_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
